// ===== hdl/hsr_pkg.sv =====
package hsr_pkg;

    localparam int MAX_STEPS_DEF = 16;

    localparam int DIV_NW = 24;
    localparam int DIV_DW = 12;
    localparam int DIV_QW = 13;

    localparam int NUM_LANES = 5;
    localparam int LANE_SAT  = 0;
    localparam int LANE_HUE  = 1;
    localparam int LANE_IP   = 2;

    localparam int IP_HUE = 0;
    localparam int IP_VAL = 1;
    localparam int IP_SAT = 2;
    localparam int NUM_IP = 3;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 12;

    localparam logic [CFG_IW-1:0] REG_STEP_COUNT   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SHADOW_HUE   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_LIGHT_HUE    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SHADOW_VALUE = 3'd3;
    localparam logic [CFG_IW-1:0] REG_LIGHT_VALUE  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SHADOW_SAT   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_LIGHT_SAT    = 3'd6;

    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
    } base_t;

    typedef struct packed {
        logic [3:0] step_index;
        logic [7:0] shade_red;
        logic [7:0] shade_green;
        logic [7:0] shade_blue;
        logic       last_step;
    } shade_t;

    typedef struct packed {
        logic [4:0]         step_count;
        logic signed [11:0] shadow_hue_ofs;
        logic signed [11:0] light_hue_ofs;
        logic [9:0]         shadow_value_gain;
        logic [9:0]         light_value_gain;
        logic [9:0]         shadow_sat_gain;
        logic [9:0]         light_sat_gain;
    } cfg_t;

    typedef struct packed {
        logic [11:0]                    hue;
        logic [12:0]                    sat;
        logic [12:0]                    val;
        logic [NUM_IP-1:0][DIV_QW-1:0]  quot;
        logic [NUM_IP-1:0][DIV_DW-1:0]  rem;
        logic [NUM_IP-1:0]              neg;
    } hsv_t;

    typedef struct packed {
        logic [11:0]        hue;
        logic [12:0]        sat;
        logic [12:0]        val;
        logic signed [13:0] hue_ofs;
        logic [9:0]         val_gain;
        logic [9:0]         sat_gain;
        logic [3:0]         step_index;
        logic               last;
    } step_t;

endpackage

// ===== hdl/hsr_div.sv =====
module hsr_div
    import hsr_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              step,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic [DIV_QW-1:0] quot,
    output logic [DIV_DW-1:0] rem
);

    logic [DIV_NW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] dsh_reg, dsh_next;
    logic [DIV_QW-1:0] quot_reg, quot_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        if (load)
        begin
            rem_next  = num;
            dsh_next  = {den, {(DIV_NW-DIV_DW){1'b0}}};
            quot_next = '0;
        end
        else if (step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next  = rem_reg - dsh_reg;
                quot_next = {quot_reg[DIV_QW-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_reg[DIV_QW-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg[DIV_DW-1:0];

endmodule

// ===== hdl/hsr_conv.sv =====
module hsr_conv
    import hsr_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  base_t                              base,
    input  cfg_t                               cfg,
    input  logic [$clog2(MAX_STEPS+1)-1:0]     den,
    input  logic                               take,
    output logic                               busy,
    output logic                               full,
    output hsv_t                               hsv
);

    // v = (mx * 8192 + 255) / 510 by reciprocal multiply, exact for mx up to 255
    localparam logic [21:0] VAL_RECIP = 22'd2105377;

    logic [7:0]          r, g, b, mx, mn, d;
    logic signed [11:0]  rs, gs, bs, ds, raw;
    logic [10:0]         hn;
    logic [NUM_LANES-1:0][DIV_NW-1:0] lnum;
    logic [NUM_LANES-1:0][DIV_DW-1:0] lden;
    logic [NUM_LANES-1:0][DIV_QW-1:0] lquot;
    logic [NUM_LANES-1:0][DIV_DW-1:0] lrem;
    logic signed [12:0]  hdiff;
    logic signed [13:0]  hc;
    logic signed [10:0]  vdiff, sdiff;
    logic signed [11:0]  vc, sc;
    logic [NUM_IP-1:0]   neg_next;
    logic [DIV_DW-1:0]   dd;
    logic [20:0]         vnum;
    logic [42:0]         vprod;

    logic                run_reg, run_next;
    logic                full_reg, full_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [NUM_IP-1:0]   neg_reg;
    logic [12:0]         val_reg;

    always_comb
    begin
        r  = base.base_red;
        g  = base.base_green;
        b  = base.base_blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d  = mx - mn;
        rs = signed'({4'b0, r});
        gs = signed'({4'b0, g});
        bs = signed'({4'b0, b});
        ds = signed'({4'b0, d});
        if (mx == r)
            raw = gs - bs;
        else if (mx == g)
            raw = (ds <<< 1) + bs - rs;
        else
            raw = (ds <<< 2) + rs - gs;
        if (raw < 0)
            raw = raw + ds * 12'sd6;
        hn = raw[10:0];
    end

    assign vnum  = (21'(mx) << 13) + 21'd255;
    assign vprod = 43'(vnum) * 43'(VAL_RECIP);

    assign dd    = DIV_DW'({den, 1'b0});
    assign hdiff = {cfg.light_hue_ofs[11], cfg.light_hue_ofs}
                 - {cfg.shadow_hue_ofs[11], cfg.shadow_hue_ofs};
    assign hc    = {hdiff, 1'b0};
    assign vdiff = signed'({1'b0, cfg.light_value_gain}) - signed'({1'b0, cfg.shadow_value_gain});
    assign vc    = {vdiff, 1'b0};
    assign sdiff = signed'({1'b0, cfg.light_sat_gain}) - signed'({1'b0, cfg.shadow_sat_gain});
    assign sc    = {sdiff, 1'b0};

    always_comb
    begin
        logic [13:0] habs;
        logic [11:0] vabs, sabs;
        habs = hc[13] ? 14'(-hc) : 14'(hc);
        vabs = vc[11] ? 12'(-vc) : 12'(vc);
        sabs = sc[11] ? 12'(-sc) : 12'(sc);
        neg_next[IP_HUE] = hc[13];
        neg_next[IP_VAL] = vc[11];
        neg_next[IP_SAT] = sc[11];

        lnum[LANE_SAT] = (DIV_NW'(d) << 13) + DIV_NW'(mx);
        lden[LANE_SAT] = (mx == 8'd0) ? DIV_DW'(1) : (DIV_DW'(mx) << 1);
        lnum[LANE_HUE] = (DIV_NW'(hn) << 13) + DIV_NW'(d) * DIV_NW'(6);
        lden[LANE_HUE] = (d == 8'd0) ? DIV_DW'(1) : DIV_DW'(d) * DIV_DW'(12);
        lnum[LANE_IP+IP_HUE] = DIV_NW'(habs);
        lnum[LANE_IP+IP_VAL] = DIV_NW'(vabs);
        lnum[LANE_IP+IP_SAT] = DIV_NW'(sabs);
        lden[LANE_IP+IP_HUE] = dd;
        lden[LANE_IP+IP_VAL] = dd;
        lden[LANE_IP+IP_SAT] = dd;
    end

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        hsr_div u_div
        (
            .clk  (clk),
            .load (accept),
            .step (run_reg),
            .num  (lnum[i]),
            .den  (lden[i]),
            .quot (lquot[i]),
            .rem  (lrem[i])
        );
    end

    always_comb
    begin
        run_next  = run_reg;
        full_next = full_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(DIV_QW-1))
            begin
                run_next  = 1'b0;
                full_next = 1'b1;
            end
        end
        if (take)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            full_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            full_reg <= full_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= neg_next;
            val_reg <= vprod[42:30];
        end
    end

    assign busy = run_reg | full_reg;
    assign full = full_reg;

    always_comb
    begin
        hsv.hue = lquot[LANE_HUE][11:0];
        hsv.sat = lquot[LANE_SAT];
        hsv.val = val_reg;
        for (int j = 0; j < NUM_IP; j++)
        begin
            hsv.quot[j] = lquot[LANE_IP+j];
            hsv.rem[j]  = lrem[LANE_IP+j];
        end
        hsv.neg = neg_reg;
    end

    a_run_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(run_reg && full_reg))
        else $error("divider running while result held");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && cnt_reg == 4'(DIV_QW-1) && !accept) |=> (full_reg && !run_reg))
        else $error("divider did not finish on its last step");
    a_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> full_reg)
        else $error("hand-off without a finished conversion");

endmodule

// ===== hdl/hsr_seq.sv =====
module hsr_seq
    import hsr_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfg_t                               cfg,
    input  logic [$clog2(MAX_STEPS+1)-1:0]     den,
    input  logic                               hsv_valid,
    input  hsv_t                               hsv,
    output logic                               take,
    output logic                               step_valid,
    output step_t                              step
);

    localparam int NW = $clog2(MAX_STEPS+1);
    localparam int DW = $clog2(2*MAX_STEPS);

    logic              active_reg, active_next;
    logic [NW-1:0]     k_reg, k_next;
    logic [11:0]       hue_reg;
    logic [12:0]       sat_reg, val_reg;
    logic signed [13:0] qs_reg [NUM_IP];
    logic signed [13:0] qs_next [NUM_IP];
    logic [DW-1:0]     rs_reg [NUM_IP];
    logic [DW-1:0]     rs_next [NUM_IP];
    logic [DW-1:0]     acc_reg [NUM_IP];
    logic [DW-1:0]     acc_next [NUM_IP];
    logic signed [13:0] q_reg [NUM_IP];
    logic signed [13:0] q_next [NUM_IP];
    logic signed [13:0] base_val [NUM_IP];
    logic [DW-1:0]     dd;
    logic              last;

    assign dd   = DW'({den, 1'b0});
    assign last = active_reg && (k_reg == den);
    assign take = hsv_valid && (!active_reg || last);

    assign base_val[IP_HUE] = 14'(cfg.shadow_hue_ofs);
    assign base_val[IP_VAL] = signed'({4'b0, cfg.shadow_value_gain});
    assign base_val[IP_SAT] = signed'({4'b0, cfg.shadow_sat_gain});

    always_comb
    begin
        logic signed [13:0] qu;
        logic [DW:0]        sum;
        logic               carry;
        active_next = active_reg;
        k_next      = k_reg;
        qu          = '0;
        sum         = '0;
        carry       = 1'b0;
        for (int j = 0; j < NUM_IP; j++)
        begin
            qs_next[j]  = qs_reg[j];
            rs_next[j]  = rs_reg[j];
            acc_next[j] = acc_reg[j];
            q_next[j]   = q_reg[j];
        end
        if (take)
        begin
            active_next = 1'b1;
            k_next      = '0;
            for (int j = 0; j < NUM_IP; j++)
            begin
                qu = signed'({1'b0, hsv.quot[j]});
                if (hsv.neg[j])
                begin
                    qs_next[j] = (hsv.rem[j] != '0) ? -qu - 14'sd1 : -qu;
                    rs_next[j] = (hsv.rem[j] != '0) ? dd - DW'(hsv.rem[j]) : '0;
                end
                else
                begin
                    qs_next[j] = qu;
                    rs_next[j] = DW'(hsv.rem[j]);
                end
                acc_next[j] = DW'(den);
                q_next[j]   = '0;
            end
        end
        else if (active_reg)
        begin
            if (last)
                active_next = 1'b0;
            else
            begin
                k_next = k_reg + 1'b1;
                for (int j = 0; j < NUM_IP; j++)
                begin
                    sum         = {1'b0, acc_reg[j]} + {1'b0, rs_reg[j]};
                    carry       = sum >= {1'b0, dd};
                    acc_next[j] = carry ? DW'(sum - {1'b0, dd}) : DW'(sum);
                    q_next[j]   = q_reg[j] + qs_reg[j] + (carry ? 14'sd1 : 14'sd0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hue_reg <= hsv.hue;
            sat_reg <= hsv.sat;
            val_reg <= hsv.val;
        end
        for (int j = 0; j < NUM_IP; j++)
        begin
            qs_reg[j]  <= qs_next[j];
            rs_reg[j]  <= rs_next[j];
            acc_reg[j] <= acc_next[j];
            q_reg[j]   <= q_next[j];
        end
    end

    always_comb
    begin
        logic signed [13:0] vg, sg;
        vg              = base_val[IP_VAL] + q_reg[IP_VAL];
        sg              = base_val[IP_SAT] + q_reg[IP_SAT];
        step.hue        = hue_reg;
        step.sat        = sat_reg;
        step.val        = val_reg;
        step.hue_ofs    = base_val[IP_HUE] + q_reg[IP_HUE];
        step.val_gain   = vg[9:0];
        step.sat_gain   = sg[9:0];
        step.step_index = 4'(k_reg);
        step.last       = last;
    end

    assign step_valid = active_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (last && !hsv_valid) |=> !active_reg)
        else $error("sequence ran past its last step");
    a_k_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && !last) |=> (active_reg && k_reg == $past(k_reg) + 1'b1))
        else $error("step index skipped or repeated");
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (k_reg <= den))
        else $error("step index beyond step count");
    a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (acc_reg[IP_HUE] < dd && acc_reg[IP_VAL] < dd && acc_reg[IP_SAT] < dd))
        else $error("interpolation remainder out of range");

endmodule

// ===== hdl/hsr_shade.sv =====
module hsr_shade
    import hsr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  step_t  step,
    output logic   out_valid,
    output shade_t out
);

    // stage 1: hue shift and gains
    logic        v1_reg;
    logic [11:0] h2_reg;
    logic [12:0] s2_reg, v2_reg;
    logic [3:0]  idx1_reg;
    logic        last1_reg;
    logic [13:0] hsum;
    logic [22:0] sp, vp;
    logic [12:0] s2_next, v2_next;

    assign hsum = {2'b0, step.hue} + unsigned'(step.hue_ofs);
    assign sp   = 23'(step.sat) * 23'(step.sat_gain) + 23'd128;
    assign vp   = 23'(step.val) * 23'(step.val_gain) + 23'd128;
    assign s2_next = (sp[22:8] > 15'd4096) ? 13'd4096 : sp[20:8];
    assign v2_next = (vp[22:8] > 15'd4096) ? 13'd4096 : vp[20:8];

    // stage 2: sector and fractional terms
    logic        v2v_reg;
    logic [2:0]  sec2_reg;
    logic [12:0] v22_reg, pm_reg;
    logic [24:0] qm_reg, tm_reg;
    logic [3:0]  idx2_reg;
    logic        last2_reg;
    logic [14:0] h6;
    logic [11:0] f;
    logic [24:0] sf, sfc;

    assign h6  = 15'(h2_reg) * 15'd6;
    assign f   = h6[11:0];
    assign sf  = 25'(s2_reg) * 25'(f);
    assign sfc = 25'(s2_reg) * (25'd4096 - 25'(f));

    // stage 3: channel products
    logic        v3_reg;
    logic [36:0] cr_reg, cg_reg, cb_reg;
    logic [3:0]  idx3_reg;
    logic        last3_reg;
    logic [36:0] vv, pp, qq, tt;
    logic [36:0] cr, cg, cb;

    assign vv = 37'(v22_reg) << 24;
    assign pp = (37'(v22_reg) * 37'(pm_reg)) << 12;
    assign qq = 37'(v22_reg) * 37'(qm_reg);
    assign tt = 37'(v22_reg) * 37'(tm_reg);

    always_comb
    begin
        case (sec2_reg)
            SEC_RY:  begin cr = vv; cg = tt; cb = pp; end
            SEC_YG:  begin cr = qq; cg = vv; cb = pp; end
            SEC_GC:  begin cr = pp; cg = vv; cb = tt; end
            SEC_CB:  begin cr = pp; cg = qq; cb = vv; end
            SEC_BM:  begin cr = tt; cg = pp; cb = vv; end
            default: begin cr = vv; cg = pp; cb = qq; end
        endcase
    end

    // stage 4: back to bytes
    function automatic logic [7:0] to_byte(input logic [36:0] x);
        logic [44:0] y;
        y = 45'(x) * 45'd255 + (45'd1 << 35);
        return (y[44:36] > 9'd255) ? 8'd255 : y[43:36];
    endfunction

    logic   ov_reg;
    shade_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2v_reg <= 1'b0;
            v3_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2v_reg <= v1_reg;
            v3_reg  <= v2v_reg;
            ov_reg  <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        h2_reg    <= hsum[11:0];
        s2_reg    <= s2_next;
        v2_reg    <= v2_next;
        idx1_reg  <= step.step_index;
        last1_reg <= step.last;

        sec2_reg  <= h6[14:12];
        v22_reg   <= v2_reg;
        pm_reg    <= 13'd4096 - s2_reg;
        qm_reg    <= (25'd1 << 24) - sf;
        tm_reg    <= (25'd1 << 24) - sfc;
        idx2_reg  <= idx1_reg;
        last2_reg <= last1_reg;

        cr_reg    <= cr;
        cg_reg    <= cg;
        cb_reg    <= cb;
        idx3_reg  <= idx2_reg;
        last3_reg <= last2_reg;

        out_reg.step_index  <= idx3_reg;
        out_reg.shade_red   <= to_byte(cr_reg);
        out_reg.shade_green <= to_byte(cg_reg);
        out_reg.shade_blue  <= to_byte(cb_reg);
        out_reg.last_step   <= last3_reg;
    end

    assign out_valid = ov_reg;
    assign out       = out_reg;

endmodule

// ===== hdl/hsv_shade_ramp_top.sv =====
// a base colour passes the color conversion, step sequencer and shade pipeline in turn;
//   its shades then come out one shade per cycle; the rate of base colours is bound by
//   the step count n and the 13-step shift-subtract divider lanes of the conversion
// a new base colour is taken while the previous one is still shading
// reset: asynchronous, clears control and loads register defaults; no memories to clear
// results are strobed for one cycle; the receiver cannot stall
module hsv_shade_ramp_top
    import hsr_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  base_t             base,
    output logic              busy,
    output shade_t            shade,
    output logic              shade_valid,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam int NW = $clog2(MAX_STEPS+1);

    cfg_t          cfg_reg;
    logic [NW-1:0] den;
    logic          accept;
    logic          conv_busy, conv_full, take;
    hsv_t          hsv;
    logic          step_valid;
    step_t         step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_count        <= 5'd8;
            cfg_reg.shadow_hue_ofs    <= '0;
            cfg_reg.light_hue_ofs     <= '0;
            cfg_reg.shadow_value_gain <= 10'd256;
            cfg_reg.light_value_gain  <= 10'd256;
            cfg_reg.shadow_sat_gain   <= 10'd256;
            cfg_reg.light_sat_gain    <= 10'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEP_COUNT:   cfg_reg.step_count        <= cfg_data[4:0];
                REG_SHADOW_HUE:   cfg_reg.shadow_hue_ofs    <= signed'(cfg_data[11:0]);
                REG_LIGHT_HUE:    cfg_reg.light_hue_ofs     <= signed'(cfg_data[11:0]);
                REG_SHADOW_VALUE: cfg_reg.shadow_value_gain <= cfg_data[9:0];
                REG_LIGHT_VALUE:  cfg_reg.light_value_gain  <= cfg_data[9:0];
                REG_SHADOW_SAT:   cfg_reg.shadow_sat_gain   <= cfg_data[9:0];
                REG_LIGHT_SAT:    cfg_reg.light_sat_gain    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // last step index, n - 1 after clamping n to 2..MAX_STEPS
    always_comb
    begin
        if (cfg_reg.step_count < 5'd2)
            den = NW'(1);
        else if (32'(cfg_reg.step_count) > 32'(MAX_STEPS))
            den = NW'(MAX_STEPS - 1);
        else
            den = NW'(cfg_reg.step_count - 5'd1);
    end

    assign busy   = conv_busy;
    assign accept = start & ~conv_busy;

    hsr_conv #(.MAX_STEPS(MAX_STEPS)) u_conv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .base   (base),
        .cfg    (cfg_reg),
        .den    (den),
        .take   (take),
        .busy   (conv_busy),
        .full   (conv_full),
        .hsv    (hsv)
    );

    hsr_seq #(.MAX_STEPS(MAX_STEPS)) u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .den        (den),
        .hsv_valid  (conv_full),
        .hsv        (hsv),
        .take       (take),
        .step_valid (step_valid),
        .step       (step)
    );

    hsr_shade u_shade
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_valid),
        .step      (step),
        .out_valid (shade_valid),
        .out       (shade)
    );

endmodule
